### hw/rtl/bloom_filter_membership_unit_macros.svh
// assertion macros for the bloom filter membership unit
`ifndef BLOOM_FILTER_MEMBERSHIP_UNIT_MACROS_SVH
`define BLOOM_FILTER_MEMBERSHIP_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define BFM_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define BFM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bfm_pkg.sv
package bfm_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } bfm_cmd_t;

    localparam logic [0:0] REG_BITS_IN_USE   = 1'b0;
    localparam logic [0:0] REG_HASHES_IN_USE = 1'b1;
    localparam int CFG_WIDTH     = 15;
    localparam int CFG_IDX_WIDTH = 1;
    localparam logic [31:0] DJB2_INIT = 32'd5381;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] key_byte;
        logic       byte_valid;
        logic       last;
    } bfm_in_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       answer;
    } bfm_out_t;

    function automatic logic [31:0] mix_seed(input logic [31:0] i);
        logic [31:0] x;
        x = (i ^ 32'd61) ^ (i >> 16);
        x = x + (x << 3);
        x = x ^ (x >> 4);
        x = x * 32'h27d4eb2d;
        x = x ^ (x >> 15);
        return x;
    endfunction

endpackage

### hw/rtl/bfm_ram.sv
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/bfm_mod.sv
// serial remainder: one quotient bit per cycle, from the dividend's top bit down
module bfm_mod #(
    parameter int MW = 15
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [MW-1:0] modulus,
    output logic          done,
    output logic [MW-1:0] remainder
);
    logic [31:0] num_reg;
    logic [MW:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [MW+1:0] shifted;
    logic [MW+1:0] diff;

    always_comb begin
        shifted = {rem_reg, num_reg[31]};
        diff    = shifted - {2'b00, modulus};
    end

    assign remainder = rem_reg[MW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                num_reg  <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[30:0], 1'b0};
                if (!diff[MW+1]) begin
                    rem_reg <= diff[MW:0];
                end else begin
                    rem_reg <= shifted[MW:0];
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

### hw/rtl/bloom_filter_membership_unit.sv
// channel | ports                         | payload
// s       | s_valid / s_ready / s_data    | command, key_byte, byte_valid, last
// m       | m_valid / m_ready / m_data    | result_kind, answer
// cfg     | cfg_we / cfg_index / cfg_data | bits_in_use, hashes_in_use
// non-last requests: all djb2 accumulators update in parallel on acceptance
// a last add/check runs, per hash, a serial remainder, then a read, compare and
// write-back of the bit store through one ram port; a check stops at a clear bit
// reset starts a clearing pass over all MAX_BITS bits; a clear request does the same
// s_ready is low during a clearing pass or key-end work, or while a result waits on m_ready
module bloom_filter_membership_unit #(
    parameter int MAX_BITS   = 16384,
    parameter int MAX_HASHES = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bfm_pkg::bfm_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bfm_pkg::bfm_out_t               m_data,
    input  logic                            cfg_we,
    input  logic [bfm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [bfm_pkg::CFG_WIDTH-1:0]   cfg_data
);
    import bfm_pkg::*;

    localparam int AW = $clog2(MAX_BITS);
    localparam int MW = $clog2(MAX_BITS + 1);
    localparam int HW = $clog2(MAX_HASHES + 1);
    localparam int IW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_WAIT, ST_EVAL, ST_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] acc_reg [MAX_HASHES];
    logic [CFG_WIDTH-1:0] bits_reg;
    logic [3:0] hashes_reg;
    logic [AW-1:0] clr_reg;
    logic [IW-1:0] idx_reg;
    logic [1:0] cmd_reg;
    logic answer_reg;
    logic [AW-1:0] pos_reg;
    logic [MW-1:0] m_eff;
    logic [HW-1:0] k_eff;
    logic div_start, div_done;
    logic [MW-1:0] div_rem;
    logic ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic s_fire;
    logic div_busy_reg;
    logic key_drop;

    // clamp configuration into legal range
    always_comb begin
        if (bits_reg == '0) begin
            m_eff = MW'(1);
        end else if ({17'd0, bits_reg} > 32'(MAX_BITS)) begin
            m_eff = MW'(MAX_BITS);
        end else begin
            m_eff = MW'(bits_reg);
        end
        if (hashes_reg == 4'd0) begin
            k_eff = HW'(1);
        end else if ({28'd0, hashes_reg} > 32'(MAX_HASHES)) begin
            k_eff = HW'(MAX_HASHES);
        end else begin
            k_eff = HW'(hashes_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    assign s_fire  = s_valid && s_ready;
    assign div_start = (state_reg == ST_DIV) && !div_busy_reg;

    // clear and unknown commands throw the key away, so the byte is not folded in
    assign key_drop = s_data.last
                      && (s_data.command == CMD_CLEAR || s_data.command == CMD_NONE);

    bfm_mod #(.MW(MW)) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (acc_reg[idx_reg]),
        .modulus   (m_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    bfm_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_bits (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // clearing pass writes zero; add writes one on eval
    always_comb begin
        ram_raddr = pos_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = (state_reg == ST_EVAL) && (cmd_reg == CMD_ADD);
            ram_waddr = pos_reg;
            ram_wdata = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_valid      <= 1'b0;
            bits_reg     <= 15'd16384;
            hashes_reg   <= 4'd4;
            div_busy_reg <= 1'b0;
            idx_reg      <= '0;
            for (int i = 0; i < MAX_HASHES; i++) begin
                acc_reg[i] <= DJB2_INIT ^ mix_seed(32'(i));
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_BITS_IN_USE) begin
                    bits_reg <= cfg_data;
                end else begin
                    hashes_reg <= cfg_data[3:0];
                end
            end
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_reg == AW'(MAX_BITS - 1)) begin
                        clr_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_reg <= clr_reg + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.byte_valid && !key_drop) begin
                            for (int i = 0; i < MAX_HASHES; i++) begin
                                acc_reg[i] <= acc_reg[i] * 32'd33 + {24'd0, s_data.key_byte};
                            end
                        end
                        if (s_data.last) begin
                            cmd_reg <= s_data.command;
                            idx_reg <= '0;
                            case (s_data.command)
                                CMD_ADD: begin
                                    answer_reg <= 1'b0;
                                    state_reg  <= ST_DIV;
                                end
                                CMD_CHECK: begin
                                    answer_reg <= 1'b1;
                                    state_reg  <= ST_DIV;
                                end
                                CMD_CLEAR: begin
                                    answer_reg <= 1'b0;
                                    m_valid    <= 1'b1;
                                    m_data     <= '{result_kind: CMD_CLEAR, answer: 1'b0};
                                    state_reg  <= ST_CLEAR;
                                    clr_reg    <= '0;
                                    for (int i = 0; i < MAX_HASHES; i++) begin
                                        acc_reg[i] <= DJB2_INIT ^ mix_seed(32'(i));
                                    end
                                end
                                default: begin
                                    for (int i = 0; i < MAX_HASHES; i++) begin
                                        acc_reg[i] <= DJB2_INIT ^ mix_seed(32'(i));
                                    end
                                end
                            endcase
                        end
                    end
                end
                ST_DIV: begin
                    if (!div_busy_reg) begin
                        div_busy_reg <= 1'b1;
                    end else if (div_done) begin
                        div_busy_reg <= 1'b0;
                        pos_reg      <= AW'(div_rem);
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (cmd_reg == CMD_ADD && !ram_rdata) begin
                        answer_reg <= 1'b1;
                    end
                    if (cmd_reg == CMD_CHECK && !ram_rdata) begin
                        answer_reg <= 1'b0;
                    end
                    if (idx_reg == IW'(k_eff - HW'(1))
                            || (cmd_reg == CMD_CHECK && !ram_rdata)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_OUT: begin
                    m_valid   <= 1'b1;
                    m_data    <= '{result_kind: cmd_reg, answer: answer_reg};
                    state_reg <= ST_IDLE;
                    for (int i = 0; i < MAX_HASHES; i++) begin
                        acc_reg[i] <= DJB2_INIT ^ mix_seed(32'(i));
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

### hw/rtl/bfm_checker.sv
module bfm_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input bfm_pkg::bfm_in_t       s_data,
    input logic                   m_valid,
    input logic                   m_ready,
    input bfm_pkg::bfm_out_t      m_data
);
    import bfm_pkg::*;
`include "bloom_filter_membership_unit_macros.svh"

    `BFM_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")
    `BFM_ASSERT_IMPL(a_kind, aclk, aresetn, m_valid, m_data.result_kind != CMD_NONE, "bad result kind")
    `BFM_ASSERT_IMPL(a_clear_ans, aclk, aresetn, m_valid && m_data.result_kind == CMD_CLEAR, !m_data.answer, "clear answer set")
    `BFM_ASSERT_NEXT(a_no_byte_out, aclk, aresetn, s_valid && s_ready && !s_data.last && !m_valid, !m_valid, "result without last")
endmodule

bind bloom_filter_membership_unit bfm_checker u_bfm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfm_pkg::*;

    localparam int FILTER_DEPTH = 16384;
    localparam int HASH_COUNT   = 8;
    localparam int QUIET_LIMIT  = 60000;  // clearing pass plus long hold-off, with margin
    localparam int HOLD_CYCLES  = 3000;

    // golden filter model and the queue of responses it expects
    class filter_scoreboard;
        bit          filter[FILTER_DEPTH];
        logic [31:0] acc[HASH_COUNT];
        logic [14:0] modulus_reg;
        logic [3:0]  hash_count_reg;
        bfm_out_t    expected_q[$];
        int          errors;

        function logic [31:0] seed_of(logic [31:0] idx);
            logic [31:0] x;
            x = (idx ^ 32'd61) ^ (idx >> 16);
            x = x + (x << 3);
            x = x ^ (x >> 4);
            x = x * 32'h27d4eb2d;
            return x ^ (x >> 15);
        endfunction

        function void restart();
            for (int i = 0; i < HASH_COUNT; i++) acc[i] = DJB2_INIT ^ seed_of(i);
        endfunction

        function new();
            foreach (filter[i]) filter[i] = 1'b0;
            restart();
            modulus_reg    = 15'd16384;
            hash_count_reg = 4'd4;
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
            if (idx == REG_BITS_IN_USE) modulus_reg = val;
            else hash_count_reg = val[3:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // one accepted request: fold the byte in, run the command on the last item
        function void note_request(bfm_in_t d);
            int unsigned m, k, pos;
            bfm_out_t    r;
            bfm_cmd_t    op;
            if (d.byte_valid)
                for (int i = 0; i < HASH_COUNT; i++)
                    acc[i] = acc[i] * 32'd33 + {24'd0, d.key_byte};
            if (!d.last) return;
            m  = (modulus_reg == 0) ? 1 : (modulus_reg > FILTER_DEPTH ? FILTER_DEPTH : modulus_reg);
            k  = (hash_count_reg == 0) ? 1 :
                 (hash_count_reg > HASH_COUNT ? HASH_COUNT : hash_count_reg);
            op = bfm_cmd_t'(d.command);
            r.result_kind = d.command;
            r.answer      = 1'b0;
            case (op)
                CMD_ADD: begin
                    for (int i = 0; i < k; i++) begin
                        pos = acc[i] % m;
                        if (!filter[pos]) r.answer = 1'b1;
                        filter[pos] = 1'b1;
                    end
                end
                CMD_CHECK: begin
                    r.answer = 1'b1;
                    for (int i = 0; i < k; i++) begin
                        pos = acc[i] % m;
                        if (!filter[pos]) r.answer = 1'b0;
                    end
                end
                CMD_CLEAR: begin
                    foreach (filter[i]) filter[i] = 1'b0;
                end
                default: ;
            endcase
            restart();
            if (op != CMD_NONE) expected_q.push_back(r);
        endfunction

        task check_result(bfm_out_t got);
            bfm_out_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected response kind=%0d answer=%0d",
                                 got.result_kind, got.answer));
                return;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind)
                report($sformatf("result_kind got %0d want %0d",
                                 got.result_kind, want.result_kind));
            if (got.answer !== want.answer)
                report($sformatf("answer got %0d want %0d (kind %0d)",
                                 got.answer, want.answer, want.result_kind));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    bfm_in_t                  s_data;
    logic                     m_valid;
    logic                     m_ready;
    bfm_out_t                 m_data;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_data;

    filter_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int quiet_cycles;

    bloom_filter_membership_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // response monitor: every handshake on m is checked in order
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // watchdog: give up if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bfm_in_t make_req(logic [1:0] cmd, logic [7:0] kb, bit bv, bit lst);
        bfm_in_t d;
        d.command    = cmd;
        d.key_byte   = kb;
        d.byte_valid = bv;
        d.last       = lst;
        return d;
    endfunction

    // offer one request, with an occasional random gap first, and hold it until taken
    task send_req(bfm_in_t d);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(d);
    endtask

    // a key of len bytes (some items carry no byte), then its last request
    task send_key(bfm_cmd_t op, int len, bit narrow);
        logic [7:0] kb;
        for (int j = 0; j < len; j++) begin
            kb = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            send_req(make_req(2'($urandom_range(0, 3)), kb, $urandom_range(0, 9) != 0, 1'b0));
        end
        kb = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        send_req(make_req(op, kb, 1'($urandom_range(0, 1)), 1'b1));
    endtask

    // wait for all responses and for the block to be idle again (clearing pass included)
    task drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0 || !s_ready);
    endtask

    task write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    task random_phase(int n_items, bit narrow);
        int sent, len, r;
        bfm_cmd_t op;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: lone request, mostly not closing a key
                send_req(make_req(($urandom_range(0, 3) == 0) ? 2'(CMD_ADD) :
                                  2'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 3) == 0));
                sent++;
            end else begin
                r  = $urandom_range(0, 99);
                op = (r < 2) ? CMD_CLEAR : (r < 6) ? CMD_NONE : (r < 50) ? CMD_ADD : CMD_CHECK;
                len = narrow ? $urandom_range(0, 2) : $urandom_range(0, 6);
                send_key(op, len, narrow);
                sent += len + 1;
            end
        end
    endtask

    initial begin
        // register settings swept across the run, extremes included
        logic [14:0] mod_set[7]  = '{15'd16384, 15'd1, 15'd0, 15'd32767, 15'd8, 15'd1000, 15'd64};
        logic [14:0] hash_set[7] = '{15'd4, 15'd1, 15'd0, 15'd15, 15'd8, 15'd3, 15'd2};
        int idle_set[4]  = '{0, 49, 0, 23};
        int stall_set[4] = '{0, 0, 49, 23};

        sb             = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty keys, extreme bytes, repeated add, ignored items
        send_req(make_req(CMD_CHECK, 8'h00, 1'b0, 1'b1));   // empty key not yet present
        send_req(make_req(CMD_ADD,   8'h00, 1'b0, 1'b1));   // empty key add
        send_req(make_req(CMD_CHECK, 8'hff, 1'b0, 1'b1));   // empty key now present
        send_req(make_req(CMD_NONE,  8'h00, 1'b1, 1'b0));
        send_req(make_req(CMD_CLEAR, 8'hff, 1'b0, 1'b0));   // no byte, no last: nothing
        send_req(make_req(CMD_ADD,   8'hff, 1'b1, 1'b1));   // add {00, ff}
        send_req(make_req(CMD_CHECK, 8'h00, 1'b1, 1'b0));
        send_req(make_req(CMD_CHECK, 8'hff, 1'b1, 1'b1));   // check {00, ff}
        send_req(make_req(CMD_ADD,   8'h00, 1'b1, 1'b0));
        send_req(make_req(CMD_ADD,   8'hff, 1'b1, 1'b1));   // re-add: nothing new
        send_req(make_req(CMD_ADD,   8'h55, 1'b1, 1'b0));
        send_req(make_req(CMD_NONE,  8'haa, 1'b1, 1'b1));   // discarded key
        send_req(make_req(CMD_CHECK, 8'haa, 1'b0, 1'b1));   // accumulators restarted
        send_req(make_req(CMD_CLEAR, 8'h12, 1'b1, 1'b1));   // clear with a byte
        send_req(make_req(CMD_CHECK, 8'h00, 1'b0, 1'b1));   // empty key gone after clear
        send_req(make_req(CMD_CHECK, 8'h00, 1'b1, 1'b0));
        send_req(make_req(CMD_CHECK, 8'hff, 1'b1, 1'b1));

        // m = 1: every hash lands on bit 0, so repeated hits in one add
        write_reg(REG_BITS_IN_USE, 15'd1);
        write_reg(REG_HASHES_IN_USE, 15'd8);
        send_req(make_req(CMD_CHECK, 8'h3c, 1'b1, 1'b1));
        send_req(make_req(CMD_ADD,   8'hc3, 1'b1, 1'b1));
        send_req(make_req(CMD_ADD,   8'h01, 1'b1, 1'b1));
        send_req(make_req(CMD_CHECK, 8'h80, 1'b1, 1'b1));

        // random phases: one register setting each, rotating idle patterns
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_BITS_IN_USE, mod_set[p]);
            write_reg(REG_HASHES_IN_USE, hash_set[p]);
            send_idle_pct  = idle_set[p % 4];
            recv_stall_pct = stall_set[p % 4];
            if (p == 4) hold_req = 1'b1;   // long hold-off fills the block
            random_phase(95, 1'b1);
            random_phase(95, p[0]);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            while (sb.pending() != 0) void'(sb.expected_q.pop_front());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
